@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/urzc_pkg.sv @@
// ----------------------------------------------------------------------------
// urzc_pkg
// Types and constants for the ultrasonic range zone classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package urzc_pkg;

    localparam int URZC_ELAPSED_BITS = 24;
    localparam int PHASE_CNT_W       = 16;
    localparam int FRAC_W            = 16;
    localparam int DIST_W            = 10;
    localparam int ZONE_W            = 2;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_IDX_W         = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CM_PER_TICK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_CM       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_CM      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CM        = 3'd5;

    localparam logic [ZONE_W-1:0] ZONE_CLEAR = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_CLOSE = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_NEAR  = 2'd2;

    typedef struct packed {
        logic [9:0]  trigger_ticks;
        logic [15:0] echo_timeout_ticks;
        logic [15:0] cm_per_tick_q16;
        logic [9:0]  near_cm;
        logic [9:0]  close_cm;
        logic [9:0]  max_cm;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        trigger_ticks:      10'd20,
        echo_timeout_ticks: 16'd10000,
        cm_per_tick_q16:    16'd1134,
        near_cm:            10'd20,
        close_cm:           10'd40,
        max_cm:             10'd400
    };

    typedef struct packed {
        logic start_request;
        logic echo_level;
    } in_beat_t;

    typedef struct packed {
        logic              trigger_out;
        logic              busy_res;
        logic              done_res;
        logic              no_echo;
        logic [DIST_W-1:0] distance_cm;
        logic [ZONE_W-1:0] zone;
    } out_beat_t;

endpackage

`default_nettype wire

@@ src/urzc_meas.sv @@
// ----------------------------------------------------------------------------
// urzc_meas
// Measurement sequencer: trigger, echo wait, echo timing, distance and zone.
// Distance is the elapsed count times cm_per_tick, formed on the echo-fall beat.
// ----------------------------------------------------------------------------
`default_nettype none

module urzc_meas
    import urzc_pkg::*;
#(
    parameter int ELAPSED_BITS = URZC_ELAPSED_BITS
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire in_beat_t  in_beat,
    input  wire cfg_t      cfg,
    output out_beat_t      result
);

    localparam int PROD_W = ELAPSED_BITS + FRAC_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_RISE,
        PH_FALL
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [PHASE_CNT_W-1:0]    phase_count_reg, phase_count_next, pc_inc;
    logic [ELAPSED_BITS-1:0]   elapsed_reg, elapsed_next;
    logic [PROD_W-1:0]         prod;
    logic [DIST_W-1:0]         distance_reg, distance_next;
    logic [ZONE_W-1:0]         zone_reg, zone_next;
    logic [ELAPSED_BITS-1:0]   whole;
    logic                      trig, done, noecho;

    assign prod  = {{FRAC_W{1'b0}}, elapsed_reg}
                 * {{ELAPSED_BITS{1'b0}}, cfg.cm_per_tick_q16};
    assign whole = prod[PROD_W-1:FRAC_W];

    always_comb
    begin
        phase_next       = phase_reg;
        phase_count_next = phase_count_reg;
        elapsed_next     = elapsed_reg;
        distance_next    = distance_reg;
        zone_next        = zone_reg;
        trig             = 1'b0;
        done             = 1'b0;
        noecho           = 1'b0;

        if (phase_reg == PH_IDLE && in_beat.start_request)
        begin
            phase_next       = PH_TRIG;
            phase_count_next = '0;
            elapsed_next     = '0;
        end

        pc_inc = phase_count_next + 16'd1;

        unique case (phase_next)
            PH_TRIG:
            begin
                trig             = 1'b1;
                phase_count_next = pc_inc;
                if (pc_inc >= {6'd0, cfg.trigger_ticks})
                begin
                    phase_next       = PH_RISE;
                    phase_count_next = '0;
                end
            end
            PH_RISE:
            begin
                if (elapsed_next != '1)
                begin
                    elapsed_next = elapsed_next + ELAPSED_BITS'(1);
                end
                if (in_beat.echo_level)
                begin
                    phase_next = PH_FALL;
                end
                else
                begin
                    phase_count_next = pc_inc;
                    if (pc_inc >= cfg.echo_timeout_ticks || pc_inc == '0)
                    begin
                        phase_next       = PH_IDLE;
                        phase_count_next = '0;
                        done             = 1'b1;
                        noecho           = 1'b1;
                    end
                end
            end
            PH_FALL:
            begin
                if (in_beat.echo_level)
                begin
                    if (elapsed_next != '1)
                    begin
                        elapsed_next = elapsed_next + ELAPSED_BITS'(1);
                    end
                end
                else
                begin
                    distance_next = (whole > {{(ELAPSED_BITS-DIST_W){1'b0}}, {DIST_W{1'b1}}})
                                  ? {DIST_W{1'b1}} : whole[DIST_W-1:0];
                    if (prod <= {{(PROD_W-DIST_W-FRAC_W){1'b0}}, cfg.max_cm, 16'h0000})
                    begin
                        if (whole < {{(ELAPSED_BITS-DIST_W){1'b0}}, cfg.close_cm})
                        begin
                            zone_next = (whole < {{(ELAPSED_BITS-DIST_W){1'b0}}, cfg.near_cm})
                                      ? ZONE_NEAR : ZONE_CLOSE;
                        end
                        else
                        begin
                            zone_next = ZONE_CLEAR;
                        end
                    end
                    phase_next       = PH_IDLE;
                    phase_count_next = '0;
                    done             = 1'b1;
                end
            end
            PH_IDLE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            phase_count_reg <= '0;
            elapsed_reg     <= '0;
            distance_reg    <= '0;
            zone_reg        <= ZONE_CLEAR;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            phase_count_reg <= phase_count_next;
            elapsed_reg     <= elapsed_next;
            distance_reg    <= distance_next;
            zone_reg        <= zone_next;
        end
    end

    always_comb
    begin
        result.trigger_out = trig;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = done;
        result.no_echo     = noecho;
        result.distance_cm = distance_next;
        result.zone        = zone_next;
    end

endmodule

`default_nettype wire

@@ src/ultrasonic_range_zone_classifier.sv @@
// Result beats are registered: valid in the cycle after the input beat is accepted.
// Throughput: one beat per cycle unless stalled; the result register frees a slot
// when its beat is taken; input is taken while out_ready is high or it is empty.
// Distance is one elapsed-by-rate multiply on the echo-fall beat, same cycle.
// Reset: asynchronous, active low; clears sequencer state, result valid and
// loads register defaults (trigger 20, timeout 10000, 1134 cm/tick Q16, 20/40/400).
// ----------------------------------------------------------------------------
// ultrasonic_range_zone_classifier
// Ultrasonic ranging with zone classification, one beat per timebase tick.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ultrasonic_range_zone_classifier
    import urzc_pkg::*;
#(
    parameter int ELAPSED_BITS = URZC_ELAPSED_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_beat_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_beat_t                  out_data
);

    cfg_t      cfg_reg;
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    out_beat_t result;
    logic      step;

    assign in_ready  = out_ready || !out_valid_reg;
    assign step      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRIGGER_TICKS: cfg_reg.trigger_ticks      <= cfg_data[9:0];
                CFG_ECHO_TIMEOUT:  cfg_reg.echo_timeout_ticks <= cfg_data;
                CFG_CM_PER_TICK:   cfg_reg.cm_per_tick_q16    <= cfg_data;
                CFG_NEAR_CM:       cfg_reg.near_cm            <= cfg_data[9:0];
                CFG_CLOSE_CM:      cfg_reg.close_cm           <= cfg_data[9:0];
                CFG_MAX_CM:        cfg_reg.max_cm             <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    urzc_meas #(
        .ELAPSED_BITS(ELAPSED_BITS)
    ) u_meas (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_beat (in_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, step, out_valid_reg)
    `ASSERT_IMPLIES(a_noecho_with_done, clk, rst_n, out_valid_reg && out_data_reg.no_echo, out_data_reg.done_res && !out_data_reg.busy_res)
    `ASSERT_IMPLIES(a_trigger_busy, clk, rst_n, out_valid_reg && out_data_reg.trigger_out, out_data_reg.busy_res && !out_data_reg.done_res)
    `ASSERT_IMPLIES(a_zone_code, clk, rst_n, out_valid_reg, out_data_reg.zone == ZONE_CLEAR || out_data_reg.zone == ZONE_CLOSE || out_data_reg.zone == ZONE_NEAR)

endmodule

`default_nettype wire
